### rtl/kst_pkg.sv
// Shared types and codes for the keyed sequential table unit.
package kst_pkg;

  // Operation codes; any code with bit 1 set is a read by index
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam int unsigned MODE_READ_BIT = 1;

  // Result status codes
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_REMOVED   = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_READ_OK   = 3'd5;
  localparam logic [2:0] ST_BAD_INDEX = 3'd6;

  // Configuration register map
  localparam logic CFG_IDX_CAPACITY = 1'b0;
  localparam logic [6:0] CAPACITY_RESET = 7'd64;

  // One stored record
  typedef struct packed {
    logic [31:0] key;
    logic [63:0] name_low;
    logic [63:0] name_mid;
    logic [31:0] name_high;
    logic [31:0] price_bits;
  } record_t;

endpackage

### rtl/kst_if.sv
// Valid/ready channel interfaces for operations and results.
interface kst_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [31:0] item_key;
  logic [5:0]         read_index;
  logic [63:0]        name_low;
  logic [63:0]        name_mid;
  logic [31:0]        name_high;
  logic [31:0]        price_bits;

  modport source (output valid, mode, item_key, read_index, name_low, name_mid,
                  name_high, price_bits, input ready);
  modport sink (input valid, mode, item_key, read_index, name_low, name_mid,
                name_high, price_bits, output ready);
endinterface

interface kst_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [6:0]         record_count;
  logic [6:0]         match_position;
  logic signed [31:0] out_key;
  logic [63:0]        out_name_low;
  logic [63:0]        out_name_mid;
  logic [31:0]        out_name_high;
  logic [31:0]        out_price_bits;

  modport source (output valid, status, record_count, match_position, out_key,
                  out_name_low, out_name_mid, out_name_high, out_price_bits,
                  input ready);
  modport sink (input valid, status, record_count, match_position, out_key,
                out_name_low, out_name_mid, out_name_high, out_price_bits,
                output ready);
endinterface

### rtl/keyed_sequential_table_unit.sv
// Top level of the keyed sequential table unit: sequencer around the record memory.
// Records sit packed at positions 0..count-1 of a single-port-read record memory, and
// every operation is one transaction in and one transaction out. An operation is taken,
// then the sequencer walks the memory one entry per cycle through its read port: a read
// by index reads its one entry; an insert scans keys for a duplicate, through all n
// records on a miss (stopping early on a hit); a remove scans up to the key and then
// moves each later record down one slot. The pace is set by the one memory read per
// cycle. A new operation is taken as soon as the sequencer is idle, even while the
// previous result still waits in the output register; the result of the next one waits
// until that register is free. The memory needs no clearing after reset: only data from
// positions below the count is ever used.
module keyed_sequential_table_unit #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  kst_in_if.sink      in_chan,
  kst_out_if.source   out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import kst_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned XW = (CW > 7) ? CW : 7;

  // sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_SHIFT  = 2'd2;
  localparam logic [1:0] S_READ   = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic [5:0]    ridx_r, ridx_nxt;
  record_t       rec_r, rec_nxt;

  logic          out_valid_r;
  logic [2:0]    out_status_r, out_status_nxt;
  logic [6:0]    out_count_r, out_count_nxt;
  logic [6:0]    out_match_r, out_match_nxt;
  record_t       out_rec_r, out_rec_nxt;
  logic          out_load;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  record_t       mem_wdata;
  record_t       mem_rdata;

  logic [6:0]    capacity;
  logic          in_fire;
  logic          out_free;
  logic [CW-1:0] ptr_c, ptr_inc;
  logic          has_next, hit, full, read_ok;
  logic [XW-1:0] count_x, depth_x;

  // configuration registers
  kst_apb_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  // record store; read address follows the next pointer so data lines up with ptr_r
  kst_record_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (ptr_nxt),
    .rdata (mem_rdata)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  // scan conditions
  assign ptr_c    = CW'(ptr_r);
  assign ptr_inc  = ptr_c + CW'(1);
  assign has_next = ptr_inc < count_r;
  assign hit      = (ptr_c < count_r) && (mem_rdata.key == rec_r.key);
  assign count_x  = XW'(count_r);
  assign depth_x  = XW'(TABLE_DEPTH);
  assign full     = (count_x >= XW'(capacity)) || (count_x >= depth_x);
  assign read_ok  = (XW'(ridx_r) < count_x) && (XW'(ridx_r) < depth_x);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    pos_nxt        = pos_r;
    mode_nxt       = mode_r;
    ridx_nxt       = ridx_r;
    rec_nxt        = rec_r;
    mem_we         = 1'b0;
    mem_waddr      = ptr_r - AW'(1);
    mem_wdata      = mem_rdata;
    out_load       = 1'b0;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_match_nxt  = out_match_r;
    out_rec_nxt    = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          mode_nxt            = in_chan.mode;
          ridx_nxt            = in_chan.read_index;
          rec_nxt.key         = in_chan.item_key;
          rec_nxt.name_low    = in_chan.name_low;
          rec_nxt.name_mid    = in_chan.name_mid;
          rec_nxt.name_high   = in_chan.name_high;
          rec_nxt.price_bits  = in_chan.price_bits;
          if (in_chan.mode[MODE_READ_BIT]) begin
            ptr_nxt   = AW'(in_chan.read_index);
            state_nxt = S_READ;
          end else begin
            ptr_nxt   = '0;
            state_nxt = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (!hit && has_next) begin
          // keep scanning
          ptr_nxt = ptr_r + AW'(1);
        end else if ((mode_r == MODE_REMOVE) && hit && has_next) begin
          // start closing the gap at the match
          pos_nxt   = ptr_r;
          ptr_nxt   = ptr_r + AW'(1);
          state_nxt = S_SHIFT;
        end else if (out_free) begin
          out_load      = 1'b1;
          out_match_nxt = hit ? 7'(ptr_c) : 7'(count_r);
          state_nxt     = S_IDLE;
          if (mode_r == MODE_REMOVE) begin
            if (hit) begin
              count_nxt      = count_r - CW'(1);
              out_status_nxt = ST_REMOVED;
            end else begin
              out_status_nxt = ST_NOT_FOUND;
            end
          end else if (full) begin
            out_status_nxt = ST_FULL;
          end else if (hit) begin
            out_status_nxt = ST_DUPLICATE;
          end else begin
            mem_we         = 1'b1;
            mem_waddr      = count_r[AW-1:0];
            mem_wdata      = rec_r;
            count_nxt      = count_r + CW'(1);
            out_status_nxt = ST_INSERTED;
          end
          out_count_nxt = 7'(count_nxt);
        end
      end
      S_SHIFT: begin
        if (has_next) begin
          mem_we  = 1'b1;
          ptr_nxt = ptr_r + AW'(1);
        end else if (out_free) begin
          mem_we         = 1'b1;
          count_nxt      = count_r - CW'(1);
          out_load       = 1'b1;
          out_status_nxt = ST_REMOVED;
          out_match_nxt  = 7'(CW'(pos_r));
          out_count_nxt  = 7'(count_nxt);
          state_nxt      = S_IDLE;
        end
      end
      S_READ: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_match_nxt = 7'd0;
          out_count_nxt = 7'(count_r);
          state_nxt     = S_IDLE;
          if (read_ok) begin
            out_status_nxt = ST_READ_OK;
            out_rec_nxt    = mem_rdata;
          end else begin
            out_status_nxt = ST_BAD_INDEX;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ptr_r   <= ptr_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // operation and result payload
  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    mode_r <= mode_nxt;
    ridx_r <= ridx_nxt;
    rec_r  <= rec_nxt;
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_count_r  <= out_count_nxt;
      out_match_r  <= out_match_nxt;
      out_rec_r    <= out_rec_nxt;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.status         = out_status_r;
  assign out_chan.record_count   = out_count_r;
  assign out_chan.match_position = out_match_r;
  assign out_chan.out_key        = out_rec_r.key;
  assign out_chan.out_name_low   = out_rec_r.name_low;
  assign out_chan.out_name_mid   = out_rec_r.name_mid;
  assign out_chan.out_name_high  = out_rec_r.name_high;
  assign out_chan.out_price_bits = out_rec_r.price_bits;

endmodule

### rtl/kst_record_mem.sv
// Record memory: one write port, one read port, registered read data.
module kst_record_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  kst_pkg::record_t wdata,
  input  logic [AW-1:0]   raddr,
  output kst_pkg::record_t rdata
);
  import kst_pkg::*;

  record_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/kst_apb_regs.sv
// APB-style configuration register block (capacity).
module kst_apb_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [6:0]  capacity
);
  import kst_pkg::*;

  logic [6:0] capacity_r;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == CFG_IDX_CAPACITY);

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAPACITY_RESET;
    end else if (wr_en) begin
      capacity_r <= pwdata[6:0];
    end
  end

  // read back
  always_comb begin
    if (paddr[2] == CFG_IDX_CAPACITY) begin
      prdata = {25'd0, capacity_r};
    end else begin
      prdata = 32'd0;
    end
  end

  assign capacity = capacity_r;

endmodule

### rtl/kst_checker.sv
// Port-level assertions for the keyed sequential table unit, with bind.
module kst_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [6:0]  record_count,
  input logic [6:0]  match_position,
  input logic [31:0] out_key,
  input logic [63:0] out_name_low,
  input logic [31:0] out_price_bits
);
  import kst_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // data fields are zero unless a read succeeded
  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != ST_READ_OK) |->
      (out_key == 32'd0) && (out_name_low == 64'd0) && (out_price_bits == 32'd0))
    else $error("record data on a non-read result");

  // a fresh insert lands at the end of the table
  a_insert_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_INSERTED) |->
      (record_count != 7'd0) && (match_position == record_count - 7'd1))
    else $error("insert position does not match count");

  // reads report position zero, and a successful one implies a nonempty table
  a_read_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((status == ST_READ_OK) || (status == ST_BAD_INDEX)) |->
      (match_position == 7'd0) && ((status == ST_BAD_INDEX) || (record_count != 7'd0)))
    else $error("read result fields inconsistent");

endmodule

bind keyed_sequential_table_unit kst_checker u_kst_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .status         (out_chan.status),
  .record_count   (out_chan.record_count),
  .match_position (out_chan.match_position),
  .out_key        (out_chan.out_key),
  .out_name_low   (out_chan.out_name_low),
  .out_price_bits (out_chan.out_price_bits)
);
